### hdl/hacc_pkg.sv
// shared types and constants for the histogram accumulator
package hacc_pkg;

   localparam int VALUE_BITS_DEF = 16;
   localparam int BIN_DEPTH_DEF  = 256;
   localparam int COUNT_BITS_DEF = 32;

   localparam logic [15:0] BIN_WIDTH_RST   = 16'd1;
   localparam logic [15:0] LOWER_LIMIT_RST = 16'd0;
   localparam logic [15:0] UPPER_LIMIT_RST = 16'd255;

   localparam logic [1:0] CSR_BIN_WIDTH   = 2'd0;
   localparam logic [1:0] CSR_LOWER_LIMIT = 2'd1;
   localparam logic [1:0] CSR_UPPER_LIMIT = 2'd2;

   localparam logic MODE_ADD  = 1'b0;
   localparam logic MODE_READ = 1'b1;

   typedef struct packed {
      logic        mode;
      logic [15:0] sample;
      logic [7:0]  bin_index;
   } req_type;

   typedef struct packed {
      logic        out_of_range;
      logic [31:0] sample_count;
      logic [15:0] smallest_seen;
      logic [15:0] largest_seen;
      logic [63:0] value_sum;
      logic [63:0] square_sum;
      logic [31:0] bin_count;
   } rsp_type;

   // classified command handed from front to back
   typedef struct packed {
      logic        reject;
      logic        mode;
      logic [15:0] sample;
      logic [16:0] bin;
   } cmd_type;

endpackage

### hdl/hacc_front.sv
// front end: limit check and iterative bin index division
module hacc_front #(
   parameter int VALUE_BITS = hacc_pkg::VALUE_BITS_DEF,
   parameter int BIN_DEPTH  = hacc_pkg::BIN_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  hacc_pkg::req_type req_data,
   input  logic [15:0]       bin_width,
   input  logic [15:0]       lower_limit,
   input  logic [15:0]       upper_limit,
   output logic              cmd_valid,
   output hacc_pkg::cmd_type cmd_data,
   input  logic              cmd_ready
);
   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_DIV  = 3'b010,
      ST_PUSH = 3'b100
   } state_type;

   localparam logic [15:0] VMASK = 16'((17'd1 << VALUE_BITS) - 17'd1);

   state_type   state_ff, state_in;
   logic [4:0]  step_ff, step_in;
   logic [15:0] quo_ff, quo_in;
   logic [16:0] rem_ff, rem_in;
   hacc_pkg::cmd_type cmd_ff, cmd_in;
   logic [15:0] v;
   logic [16:0] trial;

   assign v = req_data.sample & VMASK;
   assign trial = {rem_ff[15:0], quo_ff[15]};

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      cmd_in   = cmd_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd_in.mode   = req_data.mode;
               cmd_in.sample = v;
               cmd_in.bin    = {9'd0, req_data.bin_index};
               cmd_in.reject = 1'b0;
               if (req_data.mode == hacc_pkg::MODE_READ) begin
                  cmd_in.reject = 32'(req_data.bin_index) >= 32'(BIN_DEPTH);
                  state_in = ST_PUSH;
               end else if (v < lower_limit || v > upper_limit || bin_width == 16'd0) begin
                  cmd_in.reject = 1'b1;
                  state_in = ST_PUSH;
               end else begin
                  quo_in   = v - lower_limit;
                  rem_in   = '0;
                  step_in  = '0;
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            // restoring division, one quotient bit a cycle
            if (trial >= {1'b0, bin_width}) begin
               rem_in = trial - {1'b0, bin_width};
               quo_in = {quo_ff[14:0], 1'b1};
            end else begin
               rem_in = trial;
               quo_in = {quo_ff[14:0], 1'b0};
            end
            step_in = step_ff + 5'd1;
            if (step_ff == 5'd15) begin
               cmd_in.bin    = {1'b0, quo_in};
               cmd_in.reject = 32'(quo_in) >= 32'(BIN_DEPTH);
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            if (cmd_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      step_ff <= step_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      cmd_ff  <= cmd_in;
   end

   assign busy      = state_ff != ST_IDLE;
   assign cmd_valid = state_ff == ST_PUSH;
   assign cmd_data  = cmd_ff;
endmodule

### hdl/hacc_queue.sv
// two entry queue between front and back
module hacc_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  hacc_pkg::cmd_type in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output hacc_pkg::cmd_type out_data
);
   hacc_pkg::cmd_type mem_ff [2];
   logic       wr_ff, rd_ff;
   logic [1:0] cnt_ff;
   logic       push, pop;

   assign in_ready  = cnt_ff != 2'd2;
   assign out_valid = cnt_ff != 2'd0;
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;
   assign out_data = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wr_ff <= ~wr_ff;
         if (pop) rd_ff <= ~rd_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
      if (push) mem_ff[wr_ff] <= in_data;
   end
endmodule

### hdl/hacc_back.sv
// back end: bin store, running statistics and result strobe
module hacc_back #(
   parameter int VALUE_BITS = hacc_pkg::VALUE_BITS_DEF,
   parameter int BIN_DEPTH  = hacc_pkg::BIN_DEPTH_DEF,
   parameter int COUNT_BITS = hacc_pkg::COUNT_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   output logic              cmd_ready,
   input  hacc_pkg::cmd_type cmd_data,
   output logic              clearing,
   output logic              rsp_valid,
   output hacc_pkg::rsp_type rsp_data
);
   localparam int AW = (BIN_DEPTH > 1) ? $clog2(BIN_DEPTH) : 1;
   localparam logic [COUNT_BITS-1:0] CMAX = '1;
   localparam logic [15:0] VMASK = 16'((17'd1 << VALUE_BITS) - 17'd1);

   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_READ  = 5'b00100,
      ST_SQ    = 5'b01000,
      ST_WRITE = 5'b10000
   } state_type;

   logic [COUNT_BITS-1:0] mem [BIN_DEPTH];
   logic [COUNT_BITS-1:0] rd_data_ff;
   state_type             state_ff;
   logic [AW:0]           clr_ff;
   hacc_pkg::cmd_type     cmd_ff;
   logic [COUNT_BITS-1:0] total_ff;
   logic [15:0]           min_ff, max_ff;
   logic [63:0]           sum_ff, sq_ff;
   logic [31:0]           prod_ff;
   logic                  rsp_valid_ff;
   hacc_pkg::rsp_type     rsp_ff;
   logic [COUNT_BITS-1:0] bin_new;
   logic [COUNT_BITS-1:0] total_new;
   logic [AW-1:0]         addr;

   assign addr      = cmd_ff.bin[AW-1:0];
   assign bin_new   = (rd_data_ff == CMAX) ? CMAX : rd_data_ff + COUNT_BITS'(1);
   assign total_new = (total_ff == CMAX) ? CMAX : total_ff + COUNT_BITS'(1);
   assign cmd_ready = state_ff == ST_IDLE;
   assign clearing  = state_ff == ST_CLEAR;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
         clr_ff       <= '0;
         total_ff     <= '0;
         min_ff       <= VMASK;
         max_ff       <= '0;
         sum_ff       <= '0;
         sq_ff        <= '0;
      end else begin
         unique case (state_ff)
            ST_CLEAR: begin
               // after reset, clears the bin store one bin after another
               rsp_valid_ff <= 1'b0;
               mem[clr_ff[AW-1:0]] <= '0;
               clr_ff <= clr_ff + (AW+1)'(1);
               if (32'(clr_ff) == 32'(BIN_DEPTH - 1)) state_ff <= ST_IDLE;
            end
            ST_IDLE: begin
               rsp_valid_ff <= cmd_valid && cmd_data.reject;
               if (cmd_valid) begin
                  cmd_ff <= cmd_data;
                  if (cmd_data.reject) begin
                     rsp_ff <= '{1'b1, 32'(total_ff), min_ff, max_ff, sum_ff, sq_ff, 32'd0};
                  end else begin
                     state_ff <= ST_READ;
                  end
               end
            end
            ST_READ: begin
               rsp_valid_ff <= 1'b0;
               rd_data_ff <= mem[addr];
               prod_ff    <= cmd_ff.sample * cmd_ff.sample;
               state_ff   <= (cmd_ff.mode == hacc_pkg::MODE_READ) ? ST_WRITE : ST_SQ;
            end
            ST_SQ: begin
               rsp_valid_ff <= 1'b0;
               mem[addr] <= bin_new;
               rd_data_ff <= bin_new;
               total_ff <= total_new;
               if (cmd_ff.sample < min_ff) min_ff <= cmd_ff.sample;
               if (cmd_ff.sample > max_ff) max_ff <= cmd_ff.sample;
               sum_ff <= sum_ff + 64'(cmd_ff.sample);
               sq_ff  <= sq_ff + 64'(prod_ff);
               state_ff <= ST_WRITE;
            end
            ST_WRITE: begin
               rsp_valid_ff <= 1'b1;
               rsp_ff <= '{1'b0, 32'(total_ff), min_ff, max_ff, sum_ff, sq_ff,
                           32'(rd_data_ff)};
               state_ff <= ST_IDLE;
            end
            default: begin
               rsp_valid_ff <= 1'b0;
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
endmodule

### hdl/histogram_accumulator_core.sv
// top level of the histogram accumulator
// An add command passes the restoring divider in the front end (one quotient bit a
// cycle over 16 bits), the queue, and the read, update and write states of the back end
// before its rsp_valid strobe; the front end is free once its command enters the queue.
// A read skips the divider and the update state, a sample outside the limits is answered
// from the back end's idle state, and a bin beyond the store is flagged after the division.
// Each result is shown for one cycle with rsp_valid and cannot be stalled. After reset
// the bin store is cleared, during which busy stays high; csr writes are always accepted
// but belong only where no command is in flight.
module histogram_accumulator_core #(
   parameter int VALUE_BITS = hacc_pkg::VALUE_BITS_DEF,
   parameter int BIN_DEPTH  = hacc_pkg::BIN_DEPTH_DEF,
   parameter int COUNT_BITS = hacc_pkg::COUNT_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  hacc_pkg::req_type req_data,
   output logic              rsp_valid,
   output hacc_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [15:0]       csr_data
);
   logic [15:0] bin_width_ff, lower_ff, upper_ff;
   logic front_busy, clearing;
   logic f_valid, f_ready, q_valid, q_ready;
   hacc_pkg::cmd_type f_cmd, q_cmd;

   assign csr_ready = 1'b1;
   assign busy = front_busy || clearing;

   always_ff @(posedge clock) begin
      if (reset) begin
         bin_width_ff <= hacc_pkg::BIN_WIDTH_RST;
         lower_ff     <= hacc_pkg::LOWER_LIMIT_RST;
         upper_ff     <= hacc_pkg::UPPER_LIMIT_RST;
      end else if (csr_valid) begin
         case (csr_index)
            hacc_pkg::CSR_BIN_WIDTH:   bin_width_ff <= csr_data;
            hacc_pkg::CSR_LOWER_LIMIT: lower_ff <= csr_data;
            hacc_pkg::CSR_UPPER_LIMIT: upper_ff <= csr_data;
            default: ;
         endcase
      end
   end

   hacc_front #(.VALUE_BITS(VALUE_BITS), .BIN_DEPTH(BIN_DEPTH)) u_front (
      .clock, .reset, .start(start && !clearing), .busy(front_busy), .req_data,
      .bin_width(bin_width_ff), .lower_limit(lower_ff), .upper_limit(upper_ff),
      .cmd_valid(f_valid), .cmd_data(f_cmd), .cmd_ready(f_ready)
   );

   hacc_queue u_queue (
      .clock, .reset, .in_valid(f_valid), .in_ready(f_ready), .in_data(f_cmd),
      .out_valid(q_valid), .out_ready(q_ready), .out_data(q_cmd)
   );

   hacc_back #(.VALUE_BITS(VALUE_BITS), .BIN_DEPTH(BIN_DEPTH), .COUNT_BITS(COUNT_BITS))
   u_back (
      .clock, .reset, .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd_data(q_cmd),
      .clearing, .rsp_valid, .rsp_data
   );
endmodule

### tb/histogram_accumulator_core_tb.sv
// self-checking testbench for the histogram accumulator core
module histogram_accumulator_core_tb;

   localparam int DEPTH = hacc_pkg::BIN_DEPTH_DEF;
   localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;
   localparam int LIMIT = 400000;

   // expected statistics of the block, kept alongside it
   class hist_scoreboard;
      logic [31:0] bin_cnt [DEPTH];
      logic [31:0] total;
      logic [15:0] lo_seen, hi_seen;
      logic [63:0] vsum, sqsum;
      logic [15:0] width, lower, upper;
      hacc_pkg::rsp_type pending [$];
      int          errors;
      int          checked;

      function void clear();
         foreach (bin_cnt[i]) bin_cnt[i] = '0;
         total = '0; lo_seen = '1; hi_seen = '0; vsum = '0; sqsum = '0;
         width = hacc_pkg::BIN_WIDTH_RST;
         lower = hacc_pkg::LOWER_LIMIT_RST;
         upper = hacc_pkg::UPPER_LIMIT_RST;
         errors = 0; checked = 0;
      endfunction

      function void set_reg(logic [1:0] idx, logic [15:0] val);
         if (idx == hacc_pkg::CSR_BIN_WIDTH) width = val;
         else if (idx == hacc_pkg::CSR_LOWER_LIMIT) lower = val;
         else if (idx == hacc_pkg::CSR_UPPER_LIMIT) upper = val;
      endfunction

      function void note_request(hacc_pkg::req_type rq);
         hacc_pkg::rsp_type r;
         logic [31:0] bin;
         logic        bad;
         bad = 1'b0;
         bin = '0;
         if (rq.mode == hacc_pkg::MODE_READ) begin
            r.bin_count = bin_cnt[rq.bin_index];
         end else begin
            if (rq.sample < lower || rq.sample > upper || width == 0) bad = 1'b1;
            else begin
               bin = 32'(rq.sample - lower) / 32'(width);
               if (bin >= DEPTH) bad = 1'b1;
            end
            if (!bad) begin
               if (total != COUNT_MAX) total++;
               if (rq.sample < lo_seen) lo_seen = rq.sample;
               if (rq.sample > hi_seen) hi_seen = rq.sample;
               vsum += 64'(rq.sample);
               sqsum += 64'(rq.sample) * 64'(rq.sample);
               if (bin_cnt[bin] != COUNT_MAX) bin_cnt[bin]++;
               r.bin_count = bin_cnt[bin];
            end else begin
               r.bin_count = '0;
            end
         end
         r.out_of_range = bad;
         r.sample_count = total;
         r.smallest_seen = lo_seen;
         r.largest_seen = hi_seen;
         r.value_sum = vsum;
         r.square_sum = sqsum;
         pending.push_back(r);
      endfunction

      task report(string what, logic [63:0] got, logic [63:0] want);
         $display("mismatch %0s: got %0h expected %0h at %0t", what, got, want, $realtime);
         errors++;
      endtask

      task check_result(hacc_pkg::rsp_type r);
         hacc_pkg::rsp_type e;
         if (pending.size() == 0) begin
            report("unexpected result", 64'(r), 64'd0);
            return;
         end
         e = pending.pop_front();
         checked++;
         if (r.out_of_range !== e.out_of_range)
            report("out_of_range", r.out_of_range, e.out_of_range);
         if (r.sample_count !== e.sample_count)
            report("sample_count", r.sample_count, e.sample_count);
         if (r.smallest_seen !== e.smallest_seen)
            report("smallest_seen", r.smallest_seen, e.smallest_seen);
         if (r.largest_seen !== e.largest_seen)
            report("largest_seen", r.largest_seen, e.largest_seen);
         if (r.value_sum !== e.value_sum) report("value_sum", r.value_sum, e.value_sum);
         if (r.square_sum !== e.square_sum) report("square_sum", r.square_sum, e.square_sum);
         if (r.bin_count !== e.bin_count) report("bin_count", r.bin_count, e.bin_count);
      endtask
   endclass

   logic        clock, reset, start, busy, rsp_valid, csr_valid, csr_ready;
   hacc_pkg::req_type req_data;
   hacc_pkg::rsp_type rsp_data;
   logic [1:0]  csr_index;
   logic [15:0] csr_data;
   int          cycles;
   int          n_adds, n_reads;
   hist_scoreboard stats;

   histogram_accumulator_core u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      stats = new();
      stats.clear();
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("histogram_accumulator_core_tb: errors");
         $finish;
      end
   end

   // results cannot be held off, so every strobe is checked when it is seen
   always @(posedge clock) begin
      if (!reset && rsp_valid) stats.check_result(rsp_data);
   end

   task write_reg(logic [1:0] idx, logic [15:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      stats.set_reg(idx, val);
      csr_valid <= 1'b0;
   endtask

   task configure(logic [15:0] w, logic [15:0] lo, logic [15:0] hi);
      write_reg(hacc_pkg::CSR_BIN_WIDTH, w);
      write_reg(hacc_pkg::CSR_LOWER_LIMIT, lo);
      write_reg(hacc_pkg::CSR_UPPER_LIMIT, hi);
      @(posedge clock);
   endtask

   // start stays high across back-to-back transfers; the caller lowers it
   task issue(logic m, logic [15:0] s, logic [7:0] b);
      hacc_pkg::req_type rq;
      rq.mode = m; rq.sample = s; rq.bin_index = b;
      start <= 1'b1;
      req_data <= rq;
      do @(posedge clock); while (busy);
      stats.note_request(rq);
      if (m == hacc_pkg::MODE_READ) n_reads++; else n_adds++;
   endtask

   task pause(int n);
      start <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task drain();
      int guard;
      start <= 1'b0;
      guard = 0;
      while (stats.pending.size() != 0 && guard < 5000) begin
         @(posedge clock);
         guard++;
      end
      repeat (30) @(posedge clock);
   endtask

   task random_phase(int count, logic [15:0] lo, logic [15:0] hi);
      int     left, burst;
      logic [15:0] s;
      left = count;
      while (left > 0) begin
         burst = $urandom_range(1, 12);
         while (burst > 0 && left > 0) begin
            case ($urandom_range(0, 9))
               0: issue(hacc_pkg::MODE_READ, 16'($urandom), 8'($urandom));
               1: issue(hacc_pkg::MODE_ADD, 16'($urandom), 8'($urandom));
               default: begin
                  s = 16'($urandom_range(int'(lo), int'(hi)));
                  issue(hacc_pkg::MODE_ADD, s, 8'($urandom));
               end
            endcase
            burst--;
            left--;
         end
         if ($urandom_range(0, 2) != 0) pause($urandom_range(1, 40));
      end
      drain();
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = hacc_pkg::CSR_BIN_WIDTH;
      csr_data = '0;
      n_adds = 0;
      n_reads = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset settings, empty statistics, field extremes
      issue(hacc_pkg::MODE_READ, 16'h0000, 8'd0);
      issue(hacc_pkg::MODE_READ, 16'hFFFF, 8'd255);
      issue(hacc_pkg::MODE_ADD, 16'd0, 8'd0);
      issue(hacc_pkg::MODE_ADD, 16'd255, 8'hFF);
      issue(hacc_pkg::MODE_ADD, 16'd256, 8'd0);
      issue(hacc_pkg::MODE_ADD, 16'hFFFF, 8'd0);
      issue(hacc_pkg::MODE_ADD, 16'd255, 8'd0);
      issue(hacc_pkg::MODE_READ, 16'd0, 8'd255);
      issue(hacc_pkg::MODE_READ, 16'd0, 8'd0);
      drain();
      // zero bin width rejects everything
      configure(16'd0, 16'd0, 16'hFFFF);
      issue(hacc_pkg::MODE_ADD, 16'd5, 8'd0);
      issue(hacc_pkg::MODE_ADD, 16'hFFFF, 8'd0);
      drain();
      // lower above upper rejects everything
      configure(16'd1, 16'd100, 16'd50);
      issue(hacc_pkg::MODE_ADD, 16'd75, 8'd0);
      issue(hacc_pkg::MODE_ADD, 16'd100, 8'd0);
      drain();
      // bin beyond the store, widest bins and top of the range
      configure(16'hFFFF, 16'd0, 16'hFFFF);
      issue(hacc_pkg::MODE_ADD, 16'hFFFF, 8'd0);
      issue(hacc_pkg::MODE_ADD, 16'hFFFE, 8'd0);
      issue(hacc_pkg::MODE_READ, 16'd0, 8'd0);
      drain();
      configure(16'd1, 16'd1000, 16'hFFFF);
      issue(hacc_pkg::MODE_ADD, 16'd1255, 8'd0);
      issue(hacc_pkg::MODE_ADD, 16'd1256, 8'd0);
      issue(hacc_pkg::MODE_ADD, 16'd999, 8'd0);
      drain();

      configure(16'd1, 16'd0, 16'd255);
      random_phase(250, 16'd0, 16'd300);
      configure(16'd256, 16'd0, 16'hFFFF);
      random_phase(250, 16'd0, 16'hFFFF);
      configure(16'd37, 16'd4000, 16'd12000);
      random_phase(250, 16'd3900, 16'd13000);
      configure(16'd3, 16'hFE00, 16'hFFFF);
      random_phase(250, 16'hFD00, 16'hFFFF);
      configure(16'($urandom_range(1, 400)), 16'($urandom_range(0, 2000)), 16'hFFFF);
      random_phase(250, 16'd0, 16'hFFFF);

      $display("ran %0d add and %0d read commands, %0d results checked",
               n_adds, n_reads, stats.checked);
      $display("covered zero width, inverted limits, beyond-store bins and limit edges");
      if (stats.errors == 0 && stats.pending.size() == 0) begin
         $display("histogram_accumulator_core_tb: clean");
      end else begin
         $display("%0d mismatches, %0d results missing", stats.errors, stats.pending.size());
         $display("histogram_accumulator_core_tb: errors");
      end
      $finish;
   end

endmodule

### sim.f
hdl/hacc_pkg.sv
hdl/hacc_front.sv
hdl/hacc_queue.sv
hdl/hacc_back.sv
hdl/histogram_accumulator_core.sv
tb/histogram_accumulator_core_tb.sv
